// ===== rtl/byte_budget_lru_cache_with_pinning_core_macros.svh =====
// Assertion macros used by the cache top level.
`ifndef BYTE_BUDGET_LRU_CACHE_WITH_PINNING_CORE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_WITH_PINNING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BBLC_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define BBLC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define BBLC_ASSERT_NOW(label, clk, rst_n, a, b, msg)
`define BBLC_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ===== rtl/bblc_pkg.sv =====
// Types and codes shared by the cache cells and the cache controller.
`default_nettype none
package bblc_pkg;
	localparam int MAX_IDX_W  = 10;
	localparam int MAX_SIZE_W = 48;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_PIN    = 3'd2,
		ACT_UNPIN  = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_HIT       = 4'd0,
		ST_MISS      = 4'd1,
		ST_STALE     = 4'd2,
		ST_INSERTED  = 4'd3,
		ST_SKIPPED   = 4'd4,
		ST_PIN_OK    = 4'd5,
		ST_NOT_FOUND = 4'd6,
		ST_FULL      = 4'd7,
		ST_CLEARED   = 4'd8
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_INS,
		S_ADD,
		S_EV_CHECK,
		S_EV_SCAN,
		S_EV_REMOVE,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_CLEAR,
		OP_REMOVE,
		OP_PROMOTE,
		OP_INSERT,
		OP_PIN
	} cell_op_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] key;
		logic [39:0] size_bytes;
		logic [63:0] stamp;
	} in_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [5:0]  slot;
		logic [47:0] total_bytes;
		logic [6:0]  entry_count;
		logic [6:0]  evicted_count;
	} out_t;

	typedef struct packed {
		cell_op_t                op;
		logic                    write;
		logic                    pin_val;
		logic [MAX_IDX_W-1:0]    slot;
		logic [MAX_IDX_W-1:0]    rank;
		logic [63:0]             key;
		logic [MAX_SIZE_W-1:0]   size;
		logic [63:0]             stamp;
	} cell_cmd_t;

	typedef struct packed {
		logic                    valid;
		logic                    pinned;
		logic                    match;
		logic                    tail;
		logic [MAX_IDX_W-1:0]    rank;
		logic [MAX_SIZE_W-1:0]   size;
		logic [63:0]             stamp;
	} cell_stat_t;
endpackage
`default_nettype wire

// ===== rtl/bblc_cell.sv =====
// One cache slot: entry storage, recency rank and local compares.
`default_nettype none
module bblc_cell import bblc_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int SIZE_BITS = 40,
	parameter int INDEX     = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_cmd_t  cmd,
	output cell_stat_t      stat
);
	localparam int IW = $clog2(ENTRIES);

	logic                 valid_q;
	logic                 pinned_q;
	logic [63:0]          key_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [63:0]          stamp_q;
	logic [IW-1:0]        rank_q;
	logic                 sel;
	logic [IW-1:0]        r;

	assign sel = (cmd.slot[IW-1:0] == IW'(INDEX));
	assign r   = cmd.rank[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pinned_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					valid_q  <= 1'b0;
					pinned_q <= 1'b0;
				end
				OP_REMOVE: begin
					if (sel) begin
						valid_q  <= 1'b0;
						pinned_q <= 1'b0;
					end
				end
				OP_INSERT: begin
					if (sel) begin
						valid_q  <= 1'b1;
						pinned_q <= 1'b0;
					end
				end
				OP_PROMOTE: begin
					if (sel && cmd.write) pinned_q <= 1'b0;
				end
				OP_PIN: begin
					if (sel) pinned_q <= cmd.pin_val;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_REMOVE: begin
				if (valid_q && !sel && rank_q > r) rank_q <= rank_q - IW'(1);
			end
			OP_PROMOTE: begin
				if (sel) begin
					rank_q <= '0;
					if (cmd.write) begin
						key_q   <= cmd.key;
						size_q  <= cmd.size[SIZE_BITS-1:0];
						stamp_q <= cmd.stamp;
					end
				end else if (valid_q && rank_q < r) begin
					rank_q <= rank_q + IW'(1);
				end
			end
			OP_INSERT: begin
				if (sel) begin
					rank_q  <= '0;
					key_q   <= cmd.key;
					size_q  <= cmd.size[SIZE_BITS-1:0];
					stamp_q <= cmd.stamp;
				end else if (valid_q) begin
					rank_q <= rank_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.valid  = valid_q;
		stat.pinned = pinned_q;
		stat.match  = valid_q && (key_q == cmd.key);
		stat.tail   = valid_q && (rank_q == r);
		stat.rank   = MAX_IDX_W'(rank_q);
		stat.size   = MAX_SIZE_W'(size_q);
		stat.stamp  = stamp_q;
	end
endmodule
`default_nettype wire

// ===== rtl/byte_budget_lru_cache_with_pinning_core.sv =====
// Top level of the byte-budget LRU cache: slot cells and the sequencing controller.
//
//   channel  direction  handshake                 beat
//   in       input      in_valid / in_ready       in_t: action, key, size, stamp
//   out      output     out_valid / out_ready     out_t: status, slot, totals
//   cfg      input      cfg_valid / cfg_ready     48-bit byte budget
//
// Each item scans every slot once, one cell per cycle, then executes; an unpin or an insert
// can then check the budget. Each eviction adds a scan for the tail entry.
// A budget write runs an eviction pass with no result beat.
// Reset empties the table; no clearing pass is needed.
// A result waiting on out_ready holds the controller in its final state.
`default_nettype none
`include "byte_budget_lru_cache_with_pinning_core_macros.svh"
module byte_budget_lru_cache_with_pinning_core import bblc_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int SIZE_BITS = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [47:0] cfg_data
);
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	cell_cmd_t  cmd;
	cell_stat_t stat [ENTRIES];
	cell_stat_t cur;

	state_t               state_q, state_d;
	in_t                  item_q;
	logic [IW-1:0]        idx_q;
	logic                 found_q, free_found_q, lru_found_q, report_q, tail_pinned_q;
	logic [IW-1:0]        mslot_q, mrank_q, free_slot_q, lru_slot_q, lru_rank_q;
	logic [IW-1:0]        ins_slot_q, tail_slot_q;
	logic [47:0]          msize_q, lru_size_q, tail_size_q, stamp_size;
	logic [63:0]          mstamp_q;
	logic [47:0]          bytes_q, budget_q;
	logic [CW-1:0]        count_q, evict_q;
	logic [3:0]           status_q;
	logic [IW-1:0]        slot_q;
	out_t                 out_q;
	logic                 out_valid_q;
	logic [MAX_SIZE_W-1:0] size_wide;
	logic [SIZE_BITS-1:0] sz;
	logic [47:0]          sz48;
	logic                 last;
	logic                 hit;
	logic                 ev_more;
	logic [IW-1:0]        tail_rank;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bblc_cell #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS), .INDEX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.stat   (stat[g])
		);
	end

	function automatic logic [47:0] sub_sat(input logic [47:0] a, input logic [47:0] b);
		sub_sat = (a < b) ? 48'd0 : a - b;
	endfunction

	function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] t;
		t = {1'b0, a} + {1'b0, b};
		add_sat = t[48] ? {48{1'b1}} : t[47:0];
	endfunction

	assign size_wide  = MAX_SIZE_W'(item_q.size_bytes);
	assign sz         = size_wide[SIZE_BITS-1:0];
	assign sz48       = 48'(sz);
	assign stamp_size = MAX_SIZE_W'(sz);
	assign cur        = stat[idx_q];
	assign last       = (idx_q == IW'(ENTRIES - 1));
	assign hit        = found_q && (msize_q == stamp_size) && (mstamp_q == item_q.stamp);
	assign ev_more    = (budget_q != 48'd0) && (bytes_q > budget_q) && (count_q != '0);
	assign tail_rank  = IW'(count_q - CW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid) state_d = S_EV_CHECK;
				else if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: if (last) state_d = S_EXEC;
			S_EXEC: begin
				case (item_q.action)
					ACT_INSERT: begin
						if (budget_q == 48'd0) state_d = S_DONE;
						else if (found_q || free_found_q) state_d = S_ADD;
						else if (lru_found_q) state_d = S_INS;
						else state_d = S_DONE;
					end
					ACT_UNPIN: state_d = found_q ? S_EV_CHECK : S_DONE;
					default: state_d = S_DONE;
				endcase
			end
			S_INS: state_d = S_ADD;
			S_ADD: state_d = S_EV_CHECK;
			S_EV_CHECK: begin
				if (ev_more) state_d = S_EV_SCAN;
				else state_d = report_q ? S_DONE : S_IDLE;
			end
			S_EV_SCAN: begin
				if (cur.tail) state_d = S_EV_REMOVE;
				else if (last) state_d = report_q ? S_DONE : S_IDLE;
			end
			S_EV_REMOVE: begin
				if (tail_pinned_q) state_d = report_q ? S_DONE : S_IDLE;
				else state_d = S_EV_CHECK;
			end
			S_DONE: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = OP_NOP;
		cmd.write   = 1'b0;
		cmd.pin_val = (item_q.action == ACT_PIN);
		cmd.slot    = MAX_IDX_W'(mslot_q);
		cmd.rank    = MAX_IDX_W'(tail_rank);
		cmd.key     = item_q.key;
		cmd.size    = stamp_size;
		cmd.stamp   = item_q.stamp;
		in_ready    = (state_q == S_IDLE) && !cfg_valid;
		cfg_ready   = (state_q == S_IDLE);
		case (state_q)
			S_EXEC: begin
				case (item_q.action)
					ACT_LOOKUP: begin
						if (found_q) begin
							cmd.op   = hit ? OP_PROMOTE : OP_REMOVE;
							cmd.rank = MAX_IDX_W'(mrank_q);
						end
					end
					ACT_INSERT: begin
						if (budget_q != 48'd0) begin
							if (found_q) begin
								cmd.op    = OP_PROMOTE;
								cmd.write = 1'b1;
								cmd.rank  = MAX_IDX_W'(mrank_q);
							end else if (free_found_q) begin
								cmd.op   = OP_INSERT;
								cmd.slot = MAX_IDX_W'(free_slot_q);
							end else if (lru_found_q) begin
								cmd.op   = OP_REMOVE;
								cmd.slot = MAX_IDX_W'(lru_slot_q);
								cmd.rank = MAX_IDX_W'(lru_rank_q);
							end
						end
					end
					ACT_PIN, ACT_UNPIN: if (found_q) cmd.op = OP_PIN;
					ACT_CLEAR: cmd.op = OP_CLEAR;
					default: ;
				endcase
			end
			S_INS: begin
				cmd.op   = OP_INSERT;
				cmd.slot = MAX_IDX_W'(ins_slot_q);
			end
			S_EV_REMOVE: begin
				if (!tail_pinned_q) begin
					cmd.op   = OP_REMOVE;
					cmd.slot = MAX_IDX_W'(tail_slot_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			item_q        <= '0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			lru_found_q   <= 1'b0;
			report_q      <= 1'b0;
			tail_pinned_q <= 1'b0;
			mslot_q       <= '0;
			mrank_q       <= '0;
			free_slot_q   <= '0;
			lru_slot_q    <= '0;
			lru_rank_q    <= '0;
			ins_slot_q    <= '0;
			tail_slot_q   <= '0;
			msize_q       <= '0;
			lru_size_q    <= '0;
			tail_size_q   <= '0;
			mstamp_q      <= '0;
			bytes_q       <= '0;
			budget_q      <= '0;
			count_q       <= '0;
			evict_q       <= '0;
			status_q      <= ST_NOT_FOUND;
			slot_q        <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q        <= '0;
					evict_q      <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					lru_found_q  <= 1'b0;
					slot_q       <= '0;
					status_q     <= ST_NOT_FOUND;
					if (cfg_valid) begin
						budget_q <= cfg_data;
						report_q <= 1'b0;
					end else if (in_valid) begin
						item_q   <= in_data;
						report_q <= 1'b1;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (!found_q && cur.match) begin
						found_q  <= 1'b1;
						mslot_q  <= idx_q;
						mrank_q  <= cur.rank[IW-1:0];
						msize_q  <= cur.size;
						mstamp_q <= cur.stamp;
					end
					if (!free_found_q && !cur.valid) begin
						free_found_q <= 1'b1;
						free_slot_q  <= idx_q;
					end
					if (cur.valid && !cur.pinned &&
					    (!lru_found_q || cur.rank[IW-1:0] > lru_rank_q)) begin
						lru_found_q <= 1'b1;
						lru_slot_q  <= idx_q;
						lru_rank_q  <= cur.rank[IW-1:0];
						lru_size_q  <= cur.size;
					end
				end
				S_EXEC: begin
					case (item_q.action)
						ACT_LOOKUP: begin
							if (!found_q) begin
								status_q <= ST_MISS;
							end else if (hit) begin
								status_q <= ST_HIT;
								slot_q   <= mslot_q;
							end else begin
								status_q <= ST_STALE;
								bytes_q  <= sub_sat(bytes_q, msize_q);
								count_q  <= count_q - CW'(1);
							end
						end
						ACT_INSERT: begin
							if (budget_q == 48'd0) begin
								status_q <= ST_SKIPPED;
							end else if (found_q) begin
								bytes_q    <= sub_sat(bytes_q, msize_q);
								ins_slot_q <= mslot_q;
							end else if (free_found_q) begin
								count_q    <= count_q + CW'(1);
								ins_slot_q <= free_slot_q;
							end else if (lru_found_q) begin
								bytes_q    <= sub_sat(bytes_q, lru_size_q);
								count_q    <= count_q - CW'(1);
								evict_q    <= CW'(1);
								ins_slot_q <= lru_slot_q;
							end else begin
								status_q <= ST_FULL;
							end
						end
						ACT_PIN, ACT_UNPIN: begin
							if (found_q) begin
								status_q <= ST_PIN_OK;
								slot_q   <= mslot_q;
							end
						end
						ACT_CLEAR: begin
							status_q <= ST_CLEARED;
							bytes_q  <= '0;
							count_q  <= '0;
						end
						default: ;
					endcase
				end
				S_INS: count_q <= count_q + CW'(1);
				S_ADD: begin
					bytes_q  <= add_sat(bytes_q, sz48);
					status_q <= ST_INSERTED;
					slot_q   <= ins_slot_q;
				end
				S_EV_CHECK: idx_q <= '0;
				S_EV_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (cur.tail) begin
						tail_slot_q   <= idx_q;
						tail_size_q   <= cur.size;
						tail_pinned_q <= cur.pinned;
					end
				end
				S_EV_REMOVE: begin
					if (!tail_pinned_q) begin
						bytes_q <= sub_sat(bytes_q, tail_size_q);
						count_q <= count_q - CW'(1);
						evict_q <= evict_q + CW'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q         <= 1'b1;
						out_q.status        <= status_q;
						out_q.slot          <= 6'(slot_q);
						out_q.total_bytes   <= bytes_q;
						out_q.entry_count   <= 7'(count_q);
						out_q.evicted_count <= 7'(evict_q);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BBLC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(ENTRIES), "entry count above table size")
	`BBLC_ASSERT_NEXT(a_accept_scans, clk, arst_n, in_valid && in_ready, state_q == S_SCAN, "accepted item did not start a scan")
	`BBLC_ASSERT_NOW(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == S_DONE), "result beat raised outside completion")
	`BBLC_ASSERT_NEXT(a_cfg_no_result, clk, arst_n, cfg_valid && cfg_ready, !report_q, "budget write marked as reporting")
endmodule
`default_nettype wire
